### rtl/core/shaped_column_height_unit_macros.svh
// Assertion macros for the checker file.
`ifndef SHAPED_COLUMN_HEIGHT_UNIT_MACROS_SVH
`define SHAPED_COLUMN_HEIGHT_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SCUH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SCUH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/scuh_pkg.sv
package scuh_pkg;

  localparam int unsigned MAX_HEIGHT_DEF = 64;
  localparam int unsigned MAX_EXTENT_DEF = 4096;

  localparam int unsigned SHAPE_W    = 4;
  localparam int unsigned HEIGHT_W   = 7;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned EXTENT_W   = 13;
  localparam int unsigned RESULT_W   = 7;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  localparam int unsigned SHAPE_LSB  = 0;
  localparam int unsigned HEIGHT_LSB = SHAPE_LSB + SHAPE_W;
  localparam int unsigned POS_X_LSB  = HEIGHT_LSB + HEIGHT_W;
  localparam int unsigned POS_Y_LSB  = POS_X_LSB + POS_W;
  localparam int unsigned EXT_X_LSB  = POS_Y_LSB + POS_W;
  localparam int unsigned EXT_Y_LSB  = EXT_X_LSB + EXTENT_W;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_AUTO     = 4'd0,
    SHAPE_FLAT     = 4'd1,
    SHAPE_WALL     = 4'd2,
    SHAPE_PROP     = 4'd3,
    SHAPE_RAIL     = 4'd4,
    SHAPE_STAIRS_N = 4'd5,
    SHAPE_STAIRS_S = 4'd6,
    SHAPE_ROOF_X   = 4'd7,
    SHAPE_ROOF_Y   = 4'd8,
    SHAPE_PLATFORM = 4'd9
  } shape_e;

endpackage

### rtl/core/scuh_clamp.sv
module scuh_clamp #(
  parameter int unsigned MAX_HEIGHT = scuh_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_EXTENT = scuh_pkg::MAX_EXTENT_DEF,
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned EW = $clog2(MAX_EXTENT + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  logic [scuh_pkg::SHAPE_W-1:0]   shape_i,
  input  logic [scuh_pkg::HEIGHT_W-1:0]  height_i,
  input  logic [scuh_pkg::POS_W-1:0]     pos_x_i,
  input  logic [scuh_pkg::POS_W-1:0]     pos_y_i,
  input  logic [scuh_pkg::EXTENT_W-1:0]  extent_x_i,
  input  logic [scuh_pkg::EXTENT_W-1:0]  extent_y_i,
  output logic                           valid_o,
  output logic [scuh_pkg::SHAPE_W-1:0]   shape_o,
  output logic                           zero_o,
  output logic [HW-1:0]                  height_o,
  output logic [EW-1:0]                  extent_x_o,
  output logic [EW-1:0]                  extent_y_o,
  output logic [EW-1:0]                  pos_x_o,
  output logic [EW-1:0]                  pos_y_o
);
  import scuh_pkg::*;

  logic          valid_q;
  logic [SHAPE_W-1:0] shape_q;
  logic          zero_d, zero_q;
  logic [HW-1:0] hs_d, hs_q;
  logic [EW-1:0] ws_d, ws_q, ds_d, ds_q;
  logic [EW-1:0] xc_d, xc_q, yc_d, yc_q;
  logic [EW-1:0] wm1, dm1;

  always_comb begin
    hs_d = (32'(height_i) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_i);
    ws_d = (32'(extent_x_i) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(extent_x_i);
    ds_d = (32'(extent_y_i) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(extent_y_i);
    wm1  = ws_d - EW'(1);
    dm1  = ds_d - EW'(1);
    xc_d = (32'(pos_x_i) > 32'(wm1)) ? wm1 : EW'(pos_x_i);
    yc_d = (32'(pos_y_i) > 32'(dm1)) ? dm1 : EW'(pos_y_i);
    zero_d = (shape_i == SHAPE_FLAT) || (hs_d == '0) || (ws_d == '0) || (ds_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      shape_q <= shape_i;
      zero_q  <= zero_d;
      hs_q    <= hs_d;
      ws_q    <= ws_d;
      ds_q    <= ds_d;
      xc_q    <= xc_d;
      yc_q    <= yc_d;
    end
  end

  assign valid_o    = valid_q;
  assign shape_o    = shape_q;
  assign zero_o     = zero_q;
  assign height_o   = hs_q;
  assign extent_x_o = ws_q;
  assign extent_y_o = ds_q;
  assign pos_x_o    = xc_q;
  assign pos_y_o    = yc_q;

endmodule

### rtl/core/scuh_operand.sv
module scuh_operand #(
  parameter int unsigned MAX_HEIGHT = scuh_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_EXTENT = scuh_pkg::MAX_EXTENT_DEF,
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
  localparam int unsigned PW = HW + EW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [scuh_pkg::SHAPE_W-1:0] shape_i,
  input  logic                         zero_i,
  input  logic [HW-1:0]                height_i,
  input  logic [EW-1:0]                extent_x_i,
  input  logic [EW-1:0]                extent_y_i,
  input  logic [EW-1:0]                pos_x_i,
  input  logic [EW-1:0]                pos_y_i,
  output logic                         valid_o,
  output logic [PW-1:0]                prod_o,
  output logic [EW-1:0]                den_o,
  output logic [HW-1:0]                base_o,
  output logic                         floor_o
);
  import scuh_pkg::*;

  logic          valid_q;
  logic [PW-1:0] prod_q;
  logic [EW-1:0] den_d, den_q;
  logic [HW-1:0] base_d, base_q;
  logic          floor_d, floor_q;
  logic [HW-1:0] mul_a, half, rest;
  logic [EW-1:0] num, coord, len, near_lo, near_hi, near;
  logic [EW:0]   span2;
  logic [EW-1:0] span;

  always_comb begin
    half    = height_i >> 1;
    rest    = height_i - half;
    coord   = (shape_i == SHAPE_ROOF_X) ? pos_x_i : pos_y_i;
    len     = (shape_i == SHAPE_ROOF_X) ? extent_x_i : extent_y_i;
    near_lo = coord + EW'(1);
    near_hi = len - coord;
    near    = (near_lo < near_hi) ? near_lo : near_hi;
    span2   = {near, 1'b0};
    span    = (span2 > {1'b0, len}) ? len : span2[EW-1:0];

    mul_a   = '0;
    num     = '0;
    den_d   = EW'(1);
    base_d  = '0;
    floor_d = 1'b0;
    if (!zero_i) begin
      case (shape_i)
        SHAPE_STAIRS_N: begin
          mul_a   = height_i;
          num     = extent_y_i - pos_y_i;
          den_d   = extent_y_i;
          floor_d = 1'b1;
        end
        SHAPE_STAIRS_S: begin
          mul_a   = height_i;
          num     = pos_y_i + EW'(1);
          den_d   = extent_y_i;
          floor_d = 1'b1;
        end
        SHAPE_ROOF_X, SHAPE_ROOF_Y: begin
          mul_a  = rest;
          num    = span;
          den_d  = len;
          base_d = half;
        end
        default: begin
          base_d = height_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      prod_q  <= PW'(mul_a) * PW'(num);
      den_q   <= den_d;
      base_q  <= base_d;
      floor_q <= floor_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign den_o   = den_q;
  assign base_o  = base_q;
  assign floor_o = floor_q;

endmodule

### rtl/core/scuh_div_step.sv
module scuh_div_step #(
  parameter int unsigned MAX_HEIGHT = scuh_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_EXTENT = scuh_pkg::MAX_EXTENT_DEF,
  parameter int unsigned STEP       = 0,
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
  localparam int unsigned PW = HW + EW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [PW-1:0] rem_i,
  input  logic [EW-1:0] den_i,
  input  logic [HW-1:0] quot_i,
  input  logic [HW-1:0] base_i,
  input  logic          floor_i,
  output logic          valid_o,
  output logic [PW-1:0] rem_o,
  output logic [EW-1:0] den_o,
  output logic [HW-1:0] quot_o,
  output logic [HW-1:0] base_o,
  output logic          floor_o
);

  logic          valid_q;
  logic [PW-1:0] rem_d, rem_q, shifted;
  logic [HW-1:0] quot_d, quot_q;
  logic [EW-1:0] den_q;
  logic [HW-1:0] base_q;
  logic          floor_q;

  // One restoring step: the quotient is below 2**HW, so den << STEP never overflows.
  always_comb begin
    shifted = PW'(den_i) << STEP;
    if (rem_i >= shifted) begin
      rem_d  = rem_i - shifted;
      quot_d = quot_i | (HW'(1) << STEP);
    end else begin
      rem_d  = rem_i;
      quot_d = quot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      rem_q   <= rem_d;
      quot_q  <= quot_d;
      den_q   <= den_i;
      base_q  <= base_i;
      floor_q <= floor_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quot_o  = quot_q;
  assign base_o  = base_q;
  assign floor_o = floor_q;

endmodule

### rtl/core/shaped_column_height_unit.sv
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         shape_code, nominal_height, pos_x, pos_y, extent_x, extent_y
// m_axis    out        column_height
//
// The stages are the clamp stage, the operand and multiply stage, one restoring division
// stage per quotient bit of the HW-bit height, and the output register. One transfer is
// taken per cycle unless a stall on m_axis has filled the stages.
// Reset clears only the valid bits of the stages. A stall on m_axis holds the output
// register; earlier stages keep filling their empty slots, so no transfer is lost.
module shaped_column_height_unit #(
  parameter int unsigned MAX_HEIGHT = scuh_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_EXTENT = scuh_pkg::MAX_EXTENT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // shape_code[3:0], nominal_height[10:4], pos_x[22:11], pos_y[34:23],
  // extent_x[47:35], extent_y[60:48], zero fill[63:61]
  input  logic [scuh_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // column_height[6:0], zero fill[7]
  output logic [scuh_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import scuh_pkg::*;

  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EW = $clog2(MAX_EXTENT + 1);
  localparam int unsigned PW = HW + EW;
  localparam int unsigned NS = HW + 3;

  logic [NS-1:0] vld, adv;

  logic [SHAPE_W-1:0] c_shape;
  logic          c_zero;
  logic [HW-1:0] c_height;
  logic [EW-1:0] c_ext_x, c_ext_y, c_pos_x, c_pos_y;

  logic [PW-1:0] rem  [HW+1];
  logic [EW-1:0] den  [HW+1];
  logic [HW-1:0] quot [HW+1];
  logic [HW-1:0] base [HW+1];
  logic          flr  [HW+1];

  logic          out_valid_q;
  logic [HW:0]   sum;
  logic [RESULT_W-1:0] res_d, res_q;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];

  scuh_clamp #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_EXTENT(MAX_EXTENT)) u_clamp (
    .clk_i,
    .rst_ni,
    .adv_i      (adv[0]),
    .valid_i    (s_axis_tvalid_i),
    .shape_i    (s_axis_tdata_i[SHAPE_LSB +: SHAPE_W]),
    .height_i   (s_axis_tdata_i[HEIGHT_LSB +: HEIGHT_W]),
    .pos_x_i    (s_axis_tdata_i[POS_X_LSB +: POS_W]),
    .pos_y_i    (s_axis_tdata_i[POS_Y_LSB +: POS_W]),
    .extent_x_i (s_axis_tdata_i[EXT_X_LSB +: EXTENT_W]),
    .extent_y_i (s_axis_tdata_i[EXT_Y_LSB +: EXTENT_W]),
    .valid_o    (vld[0]),
    .shape_o    (c_shape),
    .zero_o     (c_zero),
    .height_o   (c_height),
    .extent_x_o (c_ext_x),
    .extent_y_o (c_ext_y),
    .pos_x_o    (c_pos_x),
    .pos_y_o    (c_pos_y)
  );

  scuh_operand #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_EXTENT(MAX_EXTENT)) u_operand (
    .clk_i,
    .rst_ni,
    .adv_i      (adv[1]),
    .valid_i    (vld[0]),
    .shape_i    (c_shape),
    .zero_i     (c_zero),
    .height_i   (c_height),
    .extent_x_i (c_ext_x),
    .extent_y_i (c_ext_y),
    .pos_x_i    (c_pos_x),
    .pos_y_i    (c_pos_y),
    .valid_o    (vld[1]),
    .prod_o     (rem[0]),
    .den_o      (den[0]),
    .base_o     (base[0]),
    .floor_o    (flr[0])
  );

  assign quot[0] = '0;

  for (genvar i = 0; i < HW; i++) begin : g_div
    scuh_div_step #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_EXTENT (MAX_EXTENT),
      .STEP       (HW - 1 - i)
    ) u_step (
      .clk_i,
      .rst_ni,
      .adv_i   (adv[i+2]),
      .valid_i (vld[i+1]),
      .rem_i   (rem[i]),
      .den_i   (den[i]),
      .quot_i  (quot[i]),
      .base_i  (base[i]),
      .floor_i (flr[i]),
      .valid_o (vld[i+2]),
      .rem_o   (rem[i+1]),
      .den_o   (den[i+1]),
      .quot_o  (quot[i+1]),
      .base_o  (base[i+1]),
      .floor_o (flr[i+1])
    );
  end

  // Stairs of nonzero height and extent never drop below a height of one.
  always_comb begin
    sum = {1'b0, base[HW]} + {1'b0, quot[HW]};
    if (flr[HW] && (sum == '0)) begin
      sum = (HW + 1)'(1);
    end
    res_d = RESULT_W'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv[NS-1]) begin
      out_valid_q <= vld[NS-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1] && vld[NS-2]) begin
      res_q <= res_d;
    end
  end

  assign vld[NS-1]       = out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(res_q);

endmodule

### rtl/core/scuh_checker.sv
`include "shaped_column_height_unit_macros.svh"

module scuh_checker #(
  parameter int unsigned MAX_HEIGHT = scuh_pkg::MAX_HEIGHT_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [scuh_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [scuh_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import scuh_pkg::*;

  `SCUH_ASSERT(a_in_hold, clk_i, rst_ni,
    s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i),
    "Input transfer changed while stalled.")
  `SCUH_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o),
    "Output transfer changed while stalled.")
  `SCUH_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o, "Output valid during reset.")
  `SCUH_ASSERT_ALWAYS(a_empty_ready, clk_i, !m_axis_tvalid_o |-> s_axis_tready_o,
    "Input stalled with an empty output stage.")
  `SCUH_ASSERT(a_height_range, clk_i, rst_ni,
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o) <= 32'(MAX_HEIGHT)),
    "Column height above the limit.")

endmodule

bind shaped_column_height_unit scuh_checker #(.MAX_HEIGHT(MAX_HEIGHT)) u_scuh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
